// File: hw/rtl/smds_pkg.sv
// Package for the speed mode dwell supervisor: mode and op codes, register
// indexes, register reset values and the configuration struct.
// No dependencies.
`timescale 1ns / 1ps

package smds_pkg;

  localparam int DEFAULT_TIME_BITS  = 32;
  localparam int DEFAULT_SPEED_BITS = 14;

  localparam int THR_W      = 13;
  localparam int WAIT_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_LOW    = 2'd1,
    MODE_BRAKE  = 2'd2,
    MODE_OTHER  = 2'd3
  } mode_t;

  typedef enum logic {
    OP_SAMPLE    = 1'b0,
    OP_LOAD_MODE = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE        = 3'd0,
    REG_HIGH_THR      = 3'd1,
    REG_LOW_EXIT_THR  = 3'd2,
    REG_STOP_THR      = 3'd3,
    REG_DWELL         = 3'd4,
    REG_BRAKE_WAIT    = 3'd5,
    REG_RECOVERY_WAIT = 3'd6
  } reg_idx_t;

  localparam logic [THR_W-1:0]  RST_HIGH_THR      = 13'd850;
  localparam logic [THR_W-1:0]  RST_LOW_EXIT_THR  = 13'd1300;
  localparam logic [THR_W-1:0]  RST_STOP_THR      = 13'd50;
  localparam logic [WAIT_W-1:0] RST_DWELL         = 16'd500;
  localparam logic [WAIT_W-1:0] RST_BRAKE_WAIT    = 16'd500;
  localparam logic [WAIT_W-1:0] RST_RECOVERY_WAIT = 16'd8000;

  typedef struct packed {
    logic              enable;
    logic [THR_W-1:0]  high_thr;
    logic [THR_W-1:0]  low_exit_thr;
    logic [THR_W-1:0]  stop_thr;
    logic [WAIT_W-1:0] dwell;
    logic [WAIT_W-1:0] brake_wait;
    logic [WAIT_W-1:0] recovery_wait;
  } cfg_t;

endpackage

// File: hw/rtl/speed_mode_dwell_supervisor_top.sv
// Top level of the speed mode dwell supervisor: input register, result
// register and handshake. Depends on smds_pkg, smds_cfg and smds_core.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------
//   in      | input     | in_valid / in_stall | op, velocity_mm_s, now_ms, new_mode
//   out     | output    | out_valid/out_stall | mode, recovery_pulse
//   cfg     | input     | cfg_wr_en           | cfg_index, cfg_wdata
//
// One word per cycle sustained while out_stall is low; a word reaches the result
// via the input register, then the mode/timer logic into the result register.
// Reset clears the mode to other, all dwell timers and both valid flags.
// An output stall holds the result register; the input register keeps taking
// a word and raises in_stall only once it holds a word that cannot move on.
`timescale 1ns / 1ps

module speed_mode_dwell_supervisor_top #(
  parameter int TIME_BITS  = smds_pkg::DEFAULT_TIME_BITS,
  parameter int SPEED_BITS = smds_pkg::DEFAULT_SPEED_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                op,
  input  logic signed [SPEED_BITS-1:0]        velocity_mm_s,
  input  logic [TIME_BITS-1:0]                now_ms,
  input  logic [1:0]                          new_mode,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          mode,
  output logic                                recovery_pulse,
  input  logic                                cfg_wr_en,
  input  logic [smds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [smds_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  smds_pkg::cfg_t          cfg;
  logic                    item_valid;
  logic                    item_op;
  logic [SPEED_BITS-1:0]   item_velocity;
  logic [TIME_BITS-1:0]    item_now;
  logic [1:0]              item_new_mode;
  logic                    out_free, advance, in_take;
  logic [1:0]              mode_next;
  logic                    pulse_next;

  assign out_free = !out_valid || !out_stall;
  assign advance  = item_valid && out_free;
  assign in_stall = item_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  smds_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  smds_core #(
    .TIME_BITS  (TIME_BITS),
    .SPEED_BITS (SPEED_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .item_op       (item_op),
    .item_velocity (item_velocity),
    .item_now      (item_now),
    .item_new_mode (item_new_mode),
    .cfg           (cfg),
    .mode_next     (mode_next),
    .pulse_next    (pulse_next)
  );

  // Input register: refill whenever the held word moves on or none is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_op       <= op;
      item_velocity <= velocity_mm_s;
      item_now      <= now_ms;
      item_new_mode <= new_mode;
    end
  end

  // Result register: hold while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mode           <= mode_next;
      recovery_pulse <= pulse_next;
    end
  end

endmodule

// File: hw/rtl/smds_cfg.sv
// Configuration register file for the speed mode dwell supervisor.
// Depends on smds_pkg.
`timescale 1ns / 1ps

module smds_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [smds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [smds_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output smds_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable        <= 1'b1;
      cfg.high_thr      <= smds_pkg::RST_HIGH_THR;
      cfg.low_exit_thr  <= smds_pkg::RST_LOW_EXIT_THR;
      cfg.stop_thr      <= smds_pkg::RST_STOP_THR;
      cfg.dwell         <= smds_pkg::RST_DWELL;
      cfg.brake_wait    <= smds_pkg::RST_BRAKE_WAIT;
      cfg.recovery_wait <= smds_pkg::RST_RECOVERY_WAIT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        smds_pkg::REG_ENABLE:        cfg.enable        <= cfg_wdata[0];
        smds_pkg::REG_HIGH_THR:      cfg.high_thr      <= cfg_wdata[smds_pkg::THR_W-1:0];
        smds_pkg::REG_LOW_EXIT_THR:  cfg.low_exit_thr  <= cfg_wdata[smds_pkg::THR_W-1:0];
        smds_pkg::REG_STOP_THR:      cfg.stop_thr      <= cfg_wdata[smds_pkg::THR_W-1:0];
        smds_pkg::REG_DWELL:         cfg.dwell         <= cfg_wdata[smds_pkg::WAIT_W-1:0];
        smds_pkg::REG_BRAKE_WAIT:    cfg.brake_wait    <= cfg_wdata[smds_pkg::WAIT_W-1:0];
        smds_pkg::REG_RECOVERY_WAIT: cfg.recovery_wait <= cfg_wdata[smds_pkg::WAIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/smds_core.sv
// Mode state, dwell timers, next-state logic; one word per cycle on advance.
// Depends on smds_pkg.
`timescale 1ns / 1ps

module smds_core #(
  parameter int TIME_BITS  = smds_pkg::DEFAULT_TIME_BITS,
  parameter int SPEED_BITS = smds_pkg::DEFAULT_SPEED_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  item_op,
  input  logic [SPEED_BITS-1:0] item_velocity,
  input  logic [TIME_BITS-1:0]  item_now,
  input  logic [1:0]            item_new_mode,
  input  smds_pkg::cfg_t        cfg,
  output logic [1:0]            mode_next,
  output logic                  pulse_next
);

  localparam int CMP_W = (SPEED_BITS > smds_pkg::THR_W) ? SPEED_BITS : smds_pkg::THR_W;

  smds_pkg::mode_t        mode_reg, mode_reg_next;
  logic                   slow_on, slow_on_next;
  logic                   fast_on, fast_on_next;
  logic                   brake_on, brake_on_next;
  logic                   stopped_on, stopped_on_next;
  logic [TIME_BITS-1:0]   slow_start, slow_start_next;
  logic [TIME_BITS-1:0]   fast_start, fast_start_next;
  logic [TIME_BITS-1:0]   stop_start, stop_start_next;

  logic [SPEED_BITS-1:0]  speed_mag;
  logic [CMP_W-1:0]       speed_w, high_w, low_exit_w, min_w;
  logic [TIME_BITS-1:0]   slow_elapsed, fast_elapsed, stop_elapsed;
  logic [TIME_BITS-1:0]   dwell_w, brake_w, recovery_w;
  logic                   below_high, above_exit, stopped;

  // Magnitude in SPEED_BITS unsigned; the most negative value maps exactly.
  assign speed_mag  = item_velocity[SPEED_BITS-1] ? (~item_velocity + 1'b1) : item_velocity;
  assign speed_w    = CMP_W'(speed_mag);
  assign high_w     = CMP_W'(cfg.high_thr);
  assign low_exit_w = CMP_W'(cfg.low_exit_thr);
  assign min_w      = CMP_W'(cfg.stop_thr);

  assign below_high = speed_w < high_w;
  assign above_exit = speed_w >= low_exit_w;
  assign stopped    = speed_w < min_w;

  // Modular elapsed time, wraps with the timestamp.
  assign slow_elapsed = item_now - slow_start;
  assign fast_elapsed = item_now - fast_start;
  assign stop_elapsed = item_now - stop_start;
  assign dwell_w      = TIME_BITS'(cfg.dwell);
  assign brake_w      = TIME_BITS'(cfg.brake_wait);
  assign recovery_w   = TIME_BITS'(cfg.recovery_wait);

  always_comb begin
    mode_reg_next   = mode_reg;
    slow_on_next    = slow_on;
    fast_on_next    = fast_on;
    brake_on_next   = brake_on;
    stopped_on_next = stopped_on;
    slow_start_next = slow_start;
    fast_start_next = fast_start;
    stop_start_next = stop_start;
    pulse_next      = 1'b0;

    if (item_op == smds_pkg::OP_LOAD_MODE) begin
      mode_reg_next = smds_pkg::mode_t'(item_new_mode);
    end else if (cfg.enable) begin
      case (mode_reg)
        smds_pkg::MODE_NORMAL: begin
          fast_on_next    = 1'b0;
          brake_on_next   = 1'b0;
          stopped_on_next = 1'b0;
          if (below_high) begin
            if (!slow_on) begin
              slow_start_next = item_now;
              slow_on_next    = 1'b1;
            end else if (slow_elapsed >= dwell_w) begin
              mode_reg_next = smds_pkg::MODE_LOW;
              slow_on_next  = 1'b0;
            end
          end else begin
            slow_on_next = 1'b0;
          end
        end
        smds_pkg::MODE_LOW: begin
          slow_on_next = 1'b0;
          if (above_exit) begin
            if (!fast_on) begin
              fast_start_next = item_now;
              fast_on_next    = 1'b1;
            end else if (fast_elapsed >= dwell_w) begin
              mode_reg_next = smds_pkg::MODE_NORMAL;
              fast_on_next  = 1'b0;
            end
          end else begin
            fast_on_next = 1'b0;
          end
          // Brake check comes last so it wins over the return to normal.
          if (stopped) begin
            if (!brake_on) begin
              stop_start_next = item_now;
              brake_on_next   = 1'b1;
            end else if (stop_elapsed > brake_w) begin
              mode_reg_next = smds_pkg::MODE_BRAKE;
              brake_on_next = 1'b0;
            end
          end else begin
            brake_on_next = 1'b0;
          end
        end
        default: begin
          if (stopped) begin
            if (!stopped_on) begin
              stop_start_next = item_now;
              stopped_on_next = 1'b1;
            end else if (stop_elapsed > recovery_w) begin
              pulse_next      = 1'b1;
              stopped_on_next = 1'b0;
            end
          end else begin
            stopped_on_next = 1'b0;
          end
        end
      endcase
    end
  end

  assign mode_next = mode_reg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg   <= smds_pkg::MODE_OTHER;
      slow_on    <= 1'b0;
      fast_on    <= 1'b0;
      brake_on   <= 1'b0;
      stopped_on <= 1'b0;
      slow_start <= '0;
      fast_start <= '0;
      stop_start <= '0;
    end else if (advance) begin
      mode_reg   <= mode_reg_next;
      slow_on    <= slow_on_next;
      fast_on    <= fast_on_next;
      brake_on   <= brake_on_next;
      stopped_on <= stopped_on_next;
      slow_start <= slow_start_next;
      fast_start <= fast_start_next;
      stop_start <= stop_start_next;
    end
  end

endmodule
